FILE: design/luh_pkg.sv
// ----------------------------------------------------------------------------
// luh_pkg
// Shared types and constants for the link utilization history block.
// ----------------------------------------------------------------------------
`default_nettype none

package luh_pkg;

	localparam int HISTORY_DEPTH_DEF = 128;

	localparam int PCT_W  = 15;
	localparam int RATE_W = 48;
	localparam int CNT_W  = 64;
	localparam int SPD_W  = 48;
	localparam int MODE_W = 2;
	localparam int IDX_W  = 7;

	// divider datapath width: 96-bit denominator shifted left by 16
	localparam int DIV_W  = 112;

	localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

	localparam logic [MODE_W-1:0] MODE_TOTAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SENT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RECV  = 2'd2;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// divider jobs, run in this order
	localparam logic [1:0] JOB_SENT   = 2'd0;
	localparam logic [1:0] JOB_RECV   = 2'd1;
	localparam logic [1:0] JOB_RXRATE = 2'd2;
	localparam logic [1:0] JOB_TXRATE = 2'd3;

	localparam logic [5:0] UTIL_TOP = 6'd16;
	localparam logic [5:0] RATE_TOP = 6'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_READ,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: design/link_utilization_history_top.sv
// ----------------------------------------------------------------------------
// link_utilization_history_top
// Link traffic monitor: utilization, byte rates and a utilization history.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_stall is high while it is in work. A
// usable sample word first runs the shared 24x24 multiplier for the two
// speed*elapsed denominators, then one shared restoring divider that
// resolves one quotient bit per cycle, 17 bits for each utilization and 49
// bits for each byte rate, with a load step before each division and a final
// step that posts the result. An unusable sample (no previous sample, link
// down, time not advancing, speed change, counter going backward) goes
// straight to that final step, a history read through one registered ring
// read. The result sits in an output register, so a new word is taken while
// the previous result still waits on out_stall. The ring has no reset and
// needs no clearing pass: only entries below history_count can be read.
// ----------------------------------------------------------------------------
`default_nettype none

module link_utilization_history_top #(
	parameter int HISTORY_DEPTH = luh_pkg::HISTORY_DEPTH_DEF,
	localparam int HC_W = $clog2(HISTORY_DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_wr_en,
	input  wire logic [luh_pkg::MODE_W-1:0]   cfg_wr_data,

	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         kind,
	input  wire logic [luh_pkg::CNT_W-1:0]    rx_bytes,
	input  wire logic [luh_pkg::CNT_W-1:0]    tx_bytes,
	input  wire logic [luh_pkg::SPD_W-1:0]    tx_link_speed,
	input  wire logic [luh_pkg::SPD_W-1:0]    rx_link_speed,
	input  wire logic [luh_pkg::SPD_W-1:0]    time_ms,
	input  wire logic                         link_up,
	input  wire logic [luh_pkg::IDX_W-1:0]    read_index,

	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [luh_pkg::PCT_W-1:0]         sent_pct,
	output logic [luh_pkg::PCT_W-1:0]         recv_pct,
	output logic [luh_pkg::PCT_W-1:0]         total_pct,
	output logic [luh_pkg::RATE_W-1:0]        rx_rate,
	output logic [luh_pkg::RATE_W-1:0]        tx_rate,
	output logic [luh_pkg::PCT_W-1:0]         history_value,
	output logic [HC_W-1:0]                   history_count
);

	localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W = ((HC_W > luh_pkg::IDX_W) ? HC_W : luh_pkg::IDX_W) + 1;
	localparam int PW    = luh_pkg::PCT_W;
	localparam int RW    = luh_pkg::RATE_W;
	localparam int DW    = luh_pkg::DIV_W;
	localparam int SW    = luh_pkg::SPD_W;
	localparam int CW    = luh_pkg::CNT_W;
	localparam int ENT_W = 3 * PW;

	luh_pkg::state_t state_q, state_d;

	// configuration
	logic [luh_pkg::MODE_W-1:0] mode_q;

	// previous sample
	logic          prev_valid_q, prev_up_q;
	logic [SW-1:0] prev_time_q, prev_tx_spd_q, prev_rx_spd_q;
	logic [CW-1:0] prev_rx_q, prev_tx_q;

	// current word
	logic                       kind_q;
	logic [luh_pkg::IDX_W-1:0]  idx_q;
	logic [SW-1:0]              elapsed_q, tx_spd_q, rx_spd_q;
	logic [CW-1:0]              drx_q, dtx_q;

	// multiplier
	logic [3:0]    mstep_q;
	logic [2:0]    msel_q;
	logic [SW-1:0] mul_q;
	logic [2*SW-1:0] den_tx_q, den_rx_q;

	// divider
	logic [1:0]    job_q;
	logic [5:0]    bit_q;
	logic [DW-1:0] rem_q, dsh_q;
	logic [RW:0]   quo_q;

	// results
	logic [PW-1:0] sent_q, recv_q;
	logic [RW-1:0] rxr_q, txr_q;

	// ring
	logic [ENT_W-1:0] ring_mem [HISTORY_DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic             hit_q;
	logic [PTR_W-1:0] wp_q;
	logic [HC_W-1:0]  filled_q;

	// --------------------------------------------------------------------
	// input decode: usable-sample check and deltas against the previous one
	// --------------------------------------------------------------------
	logic in_acc, usable_c;
	assign in_stall = (state_q != luh_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign usable_c = prev_valid_q && link_up && prev_up_q && (time_ms > prev_time_q) &&
		(tx_link_speed == prev_tx_spd_q) && (rx_link_speed == prev_rx_spd_q) &&
		(rx_bytes >= prev_rx_q) && (tx_bytes >= prev_tx_q);

	// --------------------------------------------------------------------
	// shared 24x24 multiplier: step bit 2 picks the direction, bits 1:0 the
	// halves of speed and elapsed
	// --------------------------------------------------------------------
	logic [SW-1:0]   mul_a, mul_b;
	logic [SW/2-1:0] pa, pb;
	logic [2*SW-1:0] mul_sh;

	always_comb begin
		mul_a = mstep_q[2] ? rx_spd_q : tx_spd_q;
		mul_b = elapsed_q;
		pa = mstep_q[1] ? mul_a[SW-1:SW/2] : mul_a[SW/2-1:0];
		pb = mstep_q[0] ? mul_b[SW-1:SW/2] : mul_b[SW/2-1:0];
		case ({1'b0, msel_q[1]} + {1'b0, msel_q[0]})
			2'd0:    mul_sh = {{SW{1'b0}}, mul_q};
			2'd1:    mul_sh = {{(SW/2){1'b0}}, mul_q, {(SW/2){1'b0}}};
			default: mul_sh = {mul_q, {SW{1'b0}}};
		endcase
	end

	// --------------------------------------------------------------------
	// divider load values and one restoring step
	// --------------------------------------------------------------------
	logic [CW-1:0]   job_delta;
	logic [CW+11:0]  num_util;
	logic [CW+9:0]   num_rate;
	logic [2*SW-1:0] job_den;
	logic            job_util, den_zero;
	logic [DW-1:0]   ld_num, ld_den;
	logic            ge;
	logic [RW:0]     qn;
	logic [PW-1:0]   util_res;
	logic [RW-1:0]   rate_res;

	always_comb begin
		job_util  = (job_q == luh_pkg::JOB_SENT) || (job_q == luh_pkg::JOB_RECV);
		job_delta = ((job_q == luh_pkg::JOB_SENT) || (job_q == luh_pkg::JOB_TXRATE)) ?
			dtx_q : drx_q;
		job_den   = (job_q == luh_pkg::JOB_SENT) ? den_tx_q : den_rx_q;
		// 204800000 = 3125 << 16 ; 3125 = 2^11+2^10+2^5+2^4+2^2+1
		num_util = ({12'd0, job_delta} << 11) + ({12'd0, job_delta} << 10) +
			({12'd0, job_delta} << 5) + ({12'd0, job_delta} << 4) +
			({12'd0, job_delta} << 2) + {12'd0, job_delta};
		// 1000 = 1024 - 16 - 8
		num_rate = ({10'd0, job_delta} << 10) - ({10'd0, job_delta} << 4) -
			({10'd0, job_delta} << 3);
		if (job_util) begin
			ld_num   = {{(DW-CW-28){1'b0}}, num_util, 16'd0};
			ld_den   = {job_den, 16'd0};
			den_zero = (job_den == '0);
		end else begin
			ld_num   = {{(DW-CW-10){1'b0}}, num_rate};
			ld_den   = {16'd0, elapsed_q, {SW{1'b0}}};
			den_zero = 1'b0;
		end
		ge = (rem_q >= dsh_q);
		qn = {quo_q[RW-1:0], ge};
		// top quotient bit set means the result is past the clamp
		if (qn[16] || (qn[15:0] > {1'b0, luh_pkg::PCT_FULL}))
			util_res = luh_pkg::PCT_FULL;
		else
			util_res = qn[PW-1:0];
		rate_res = qn[RW] ? {RW{1'b1}} : qn[RW-1:0];
	end

	// --------------------------------------------------------------------
	// ring position of the read and result selection
	// --------------------------------------------------------------------
	logic [SUM_W-1:0] wp_x, fill_x, oldest, pos_sum;
	logic [PTR_W-1:0] rd_pos;
	logic [PW-1:0]    sum_pct;
	logic [PW-1:0]    total_c, hval_c;
	logic             fin_go;

	always_comb begin
		wp_x   = SUM_W'(wp_q);
		fill_x = SUM_W'(filled_q);
		oldest = (wp_x >= fill_x) ? (wp_x - fill_x) :
			(wp_x + SUM_W'(HISTORY_DEPTH) - fill_x);
		pos_sum = oldest + SUM_W'(idx_q);
		if (pos_sum >= SUM_W'(HISTORY_DEPTH))
			pos_sum = pos_sum - SUM_W'(HISTORY_DEPTH);
		rd_pos = pos_sum[PTR_W-1:0];

		sum_pct = sent_q + recv_q;
		total_c = ({1'b0, sent_q} + {1'b0, recv_q} > {1'b0, luh_pkg::PCT_FULL}) ?
			luh_pkg::PCT_FULL : sum_pct;

		case (mode_q)
			luh_pkg::MODE_SENT: hval_c = rd_q[PW*2-1:PW];
			luh_pkg::MODE_RECV: hval_c = rd_q[PW-1:0];
			default:            hval_c = rd_q[ENT_W-1:PW*2];
		endcase
		if (!hit_q) hval_c = '0;

		fin_go = !out_valid || !out_stall;
	end

	// --------------------------------------------------------------------
	// sequencer
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= luh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			luh_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (kind == luh_pkg::KIND_READ) state_d = luh_pkg::ST_READ;
					else if (usable_c)              state_d = luh_pkg::ST_MUL;
					else                            state_d = luh_pkg::ST_FIN;
				end
			end
			luh_pkg::ST_MUL: begin
				if (mstep_q == 4'd8) state_d = luh_pkg::ST_DLOAD;
			end
			luh_pkg::ST_DLOAD: begin
				if (job_util && den_zero)
					state_d = (job_q == luh_pkg::JOB_TXRATE) ? luh_pkg::ST_FIN :
						luh_pkg::ST_DLOAD;
				else
					state_d = luh_pkg::ST_DIV;
			end
			luh_pkg::ST_DIV: begin
				if (bit_q == 6'd0)
					state_d = (job_q == luh_pkg::JOB_TXRATE) ? luh_pkg::ST_FIN :
						luh_pkg::ST_DLOAD;
			end
			luh_pkg::ST_READ: state_d = luh_pkg::ST_FIN;
			luh_pkg::ST_FIN: begin
				if (fin_go) state_d = luh_pkg::ST_IDLE;
			end
			default: state_d = luh_pkg::ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------------
	// control state: config, previous sample, ring pointers, output valid
	// --------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= luh_pkg::MODE_TOTAL;
			prev_valid_q  <= 1'b0;
			prev_up_q     <= 1'b0;
			prev_time_q   <= '0;
			prev_tx_spd_q <= '0;
			prev_rx_spd_q <= '0;
			prev_rx_q     <= '0;
			prev_tx_q     <= '0;
			wp_q          <= '0;
			filled_q      <= '0;
			out_valid     <= 1'b0;
			mstep_q       <= '0;
			job_q         <= '0;
			bit_q         <= '0;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;

			if (in_acc && kind == luh_pkg::KIND_SAMPLE) begin
				prev_valid_q  <= 1'b1;
				prev_up_q     <= link_up;
				prev_time_q   <= time_ms;
				prev_tx_spd_q <= tx_link_speed;
				prev_rx_spd_q <= rx_link_speed;
				prev_rx_q     <= rx_bytes;
				prev_tx_q     <= tx_bytes;
			end

			if (in_acc) begin
				mstep_q <= '0;
				job_q   <= luh_pkg::JOB_SENT;
			end
			if (state_q == luh_pkg::ST_MUL) mstep_q <= mstep_q + 4'd1;
			if (state_q == luh_pkg::ST_DLOAD) begin
				if (job_util && den_zero) job_q <= job_q + 2'd1;
				else bit_q <= job_util ? luh_pkg::UTIL_TOP : luh_pkg::RATE_TOP;
			end
			if (state_q == luh_pkg::ST_DIV) begin
				bit_q <= bit_q - 6'd1;
				if (bit_q == 6'd0) job_q <= job_q + 2'd1;
			end

			if (state_q == luh_pkg::ST_FIN && fin_go) begin
				out_valid <= 1'b1;
				if (kind_q == luh_pkg::KIND_SAMPLE) begin
					wp_q <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
					if (filled_q != HC_W'(HISTORY_DEPTH)) filled_q <= filled_q + 1'b1;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// datapath registers
	// --------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q    <= kind;
			idx_q     <= read_index;
			elapsed_q <= time_ms - prev_time_q;
			tx_spd_q  <= tx_link_speed;
			rx_spd_q  <= rx_link_speed;
			drx_q     <= rx_bytes - prev_rx_q;
			dtx_q     <= tx_bytes - prev_tx_q;
			den_tx_q  <= '0;
			den_rx_q  <= '0;
			sent_q    <= '0;
			recv_q    <= '0;
			rxr_q     <= '0;
			txr_q     <= '0;
		end

		if (state_q == luh_pkg::ST_MUL) begin
			mul_q  <= SW'(pa * pb);
			msel_q <= mstep_q[2:0];
			if (mstep_q != 4'd0) begin
				if (msel_q[2]) den_rx_q <= den_rx_q + mul_sh;
				else           den_tx_q <= den_tx_q + mul_sh;
			end
		end

		if (state_q == luh_pkg::ST_DLOAD) begin
			rem_q <= ld_num;
			dsh_q <= ld_den;
			quo_q <= '0;
		end

		if (state_q == luh_pkg::ST_DIV) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= qn;
			if (bit_q == 6'd0) begin
				case (job_q)
					luh_pkg::JOB_SENT:   sent_q <= util_res;
					luh_pkg::JOB_RECV:   recv_q <= util_res;
					luh_pkg::JOB_RXRATE: rxr_q  <= rate_res;
					default:             txr_q  <= rate_res;
				endcase
			end
		end

		if (state_q == luh_pkg::ST_READ) begin
			rd_q  <= ring_mem[rd_pos];
			hit_q <= (SUM_W'(idx_q) < fill_x);
		end

		if (state_q == luh_pkg::ST_FIN && fin_go) begin
			if (kind_q == luh_pkg::KIND_SAMPLE) begin
				ring_mem[wp_q] <= {total_c, sent_q, recv_q};
				sent_pct       <= sent_q;
				recv_pct       <= recv_q;
				total_pct      <= total_c;
				rx_rate        <= rxr_q;
				tx_rate        <= txr_q;
				history_value  <= '0;
				history_count  <= (filled_q != HC_W'(HISTORY_DEPTH)) ?
					filled_q + 1'b1 : filled_q;
			end else begin
				sent_pct      <= '0;
				recv_pct      <= '0;
				total_pct     <= '0;
				rx_rate       <= '0;
				tx_rate       <= '0;
				history_value <= hval_c;
				history_count <= filled_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb_link_utilization_history_top.sv
// ----------------------------------------------------------------------------
// tb_link_utilization_history_top
// Self-checking bench for the link utilization history block: a directed
// table of sample and history-read words, then random sample streams checked
// against a bit-accurate predictor, under several idle/stall phases and
// every history_mode setting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_link_utilization_history_top;
	import luh_pkg::*;

	localparam int DEPTH = HISTORY_DEPTH_DEF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// stimulus side
	logic                 cfg_wr_en = 1'b0;
	logic [MODE_W-1:0]    cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = KIND_SAMPLE;
	logic [CNT_W-1:0]     rx_bytes = '0;
	logic [CNT_W-1:0]     tx_bytes = '0;
	logic [SPD_W-1:0]     tx_link_speed = '0;
	logic [SPD_W-1:0]     rx_link_speed = '0;
	logic [SPD_W-1:0]     time_ms = '0;
	logic                 link_up = 1'b0;
	logic [IDX_W-1:0]     read_index = '0;
	// result side
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PCT_W-1:0]     sent_pct, recv_pct, total_pct, history_value;
	logic [RATE_W-1:0]    rx_rate, tx_rate;
	logic [7:0]           history_count;

	link_utilization_history_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .rx_bytes(rx_bytes), .tx_bytes(tx_bytes),
		.tx_link_speed(tx_link_speed), .rx_link_speed(rx_link_speed),
		.time_ms(time_ms), .link_up(link_up), .read_index(read_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.sent_pct(sent_pct), .recv_pct(recv_pct), .total_pct(total_pct),
		.rx_rate(rx_rate), .tx_rate(tx_rate),
		.history_value(history_value), .history_count(history_count)
	);

	typedef struct packed {
		logic              kind;
		logic [CNT_W-1:0]  rx;
		logic [CNT_W-1:0]  tx;
		logic [SPD_W-1:0]  tx_spd;
		logic [SPD_W-1:0]  rx_spd;
		logic [SPD_W-1:0]  now;
		logic              up;
		logic [IDX_W-1:0]  idx;
	} word_in_t;

	typedef struct packed {
		logic [PCT_W-1:0]  sent;
		logic [PCT_W-1:0]  recv;
		logic [PCT_W-1:0]  total;
		logic [RATE_W-1:0] rxr;
		logic [RATE_W-1:0] txr;
		logic [PCT_W-1:0]  hval;
		logic [7:0]        hcnt;
	} word_out_t;

	// predictor state
	logic [MODE_W-1:0]  mode_q;
	logic               last_ok, last_up;
	logic [SPD_W-1:0]   last_time, last_tx_spd, last_rx_spd;
	logic [CNT_W-1:0]   last_rx, last_tx;
	logic [PCT_W-1:0]   ring_total [DEPTH];
	logic [PCT_W-1:0]   ring_sent  [DEPTH];
	logic [PCT_W-1:0]   ring_recv  [DEPTH];
	int unsigned        wr_pos, fill;

	word_out_t   expected_q[$];
	int          err_cnt = 0;
	int          idle_pct = 0, stall_pct = 0;

	// delta*204800000/(speed*elapsed), exact in 160 bits, clamped to full
	function automatic logic [PCT_W-1:0] util_of(logic [63:0] delta,
			logic [47:0] spd, logic [47:0] el);
		logic [159:0] num, den, q;
		if (spd == 0 || el == 0)
			return '0;
		num = 160'(delta) * 160'd204800000;
		den = 160'(spd) * 160'(el);
		q = num / den;
		return (q > 160'(PCT_FULL)) ? PCT_FULL : q[PCT_W-1:0];
	endfunction

	function automatic logic [RATE_W-1:0] rate_of(logic [63:0] delta, logic [47:0] el);
		logic [127:0] q;
		q = (128'(delta) * 128'd1000) / 128'(el);
		return (q > 128'(MAX48)) ? MAX48 : q[RATE_W-1:0];
	endfunction

	function automatic word_out_t predict_word(word_in_t w);
		word_out_t r;
		logic [47:0] el;
		logic [15:0] sum;
		int unsigned pos;
		r = '0;
		if (w.kind == KIND_READ) begin
			if (w.idx < fill) begin
				pos = (wr_pos + DEPTH - fill + w.idx) % DEPTH;
				case (mode_q)
					MODE_SENT: r.hval = ring_sent[pos];
					MODE_RECV: r.hval = ring_recv[pos];
					default:   r.hval = ring_total[pos];
				endcase
			end
		end else begin
			if (last_ok && w.up && last_up && w.now > last_time &&
					w.tx_spd == last_tx_spd && w.rx_spd == last_rx_spd &&
					w.rx >= last_rx && w.tx >= last_tx) begin
				el = w.now - last_time;
				r.sent = util_of(w.tx - last_tx, w.tx_spd, el);
				r.recv = util_of(w.rx - last_rx, w.rx_spd, el);
				r.rxr  = rate_of(w.rx - last_rx, el);
				r.txr  = rate_of(w.tx - last_tx, el);
			end
			sum = 16'(r.sent) + 16'(r.recv);
			r.total = (sum > 16'(PCT_FULL)) ? PCT_FULL : sum[PCT_W-1:0];
			ring_total[wr_pos] = r.total;
			ring_sent[wr_pos]  = r.sent;
			ring_recv[wr_pos]  = r.recv;
			wr_pos = (wr_pos + 1) % DEPTH;
			if (fill < DEPTH)
				fill++;
			last_ok = 1'b1;
			last_up = w.up;
			last_time = w.now;
			last_tx_spd = w.tx_spd;
			last_rx_spd = w.rx_spd;
			last_rx = w.rx;
			last_tx = w.tx;
		end
		r.hcnt = 8'(fill);
		return r;
	endfunction

	// push one word through the handshake; predictor runs on acceptance.
	// valid stays up after acceptance; the next call or drain replaces it.
	task automatic send_word(word_in_t w);
		while (($urandom % 100) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.kind;
		rx_bytes <= w.rx;
		tx_bytes <= w.tx;
		tx_link_speed <= w.tx_spd;
		rx_link_speed <= w.rx_spd;
		time_ms <= w.now;
		link_up <= w.up;
		read_index <= w.idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(predict_word(w));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] m);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_q = m;
	endtask

	// receiver: random stall, compare each accepted word
	always @(posedge clk) begin
		word_out_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected");
					err_cnt++;
				end else begin
					e = expected_q.pop_front();
					if (sent_pct !== e.sent) begin
						$error("sent_pct exp %0d got %0d", e.sent, sent_pct); err_cnt++;
					end
					if (recv_pct !== e.recv) begin
						$error("recv_pct exp %0d got %0d", e.recv, recv_pct); err_cnt++;
					end
					if (total_pct !== e.total) begin
						$error("total_pct exp %0d got %0d", e.total, total_pct); err_cnt++;
					end
					if (rx_rate !== e.rxr) begin
						$error("rx_rate exp %0d got %0d", e.rxr, rx_rate); err_cnt++;
					end
					if (tx_rate !== e.txr) begin
						$error("tx_rate exp %0d got %0d", e.txr, tx_rate); err_cnt++;
					end
					if (history_value !== e.hval) begin
						$error("history_value exp %0d got %0d", e.hval, history_value);
						err_cnt++;
					end
					if (history_count !== e.hcnt) begin
						$error("history_count exp %0d got %0d", e.hcnt, history_count);
						err_cnt++;
					end
				end
			end
			out_stall <= (($urandom % 100) < stall_pct);
		end
	end

	// directed table; chk marks rows whose result is typed in by hand
	typedef struct {
		word_in_t  w;
		bit        chk;
		word_out_t r;
	} row_t;

	localparam logic [47:0] GIG = 48'd1_000_000_000;

	function automatic word_in_t mk(logic k, logic [63:0] rx, logic [63:0] tx,
			logic [47:0] ts, logic [47:0] rs, logic [47:0] t, logic up,
			logic [6:0] idx);
		word_in_t w;
		w.kind = k; w.rx = rx; w.tx = tx; w.tx_spd = ts; w.rx_spd = rs;
		w.now = t; w.up = up; w.idx = idx;
		return w;
	endfunction

	function automatic word_out_t res(logic [14:0] s, logic [14:0] r, logic [14:0] t,
			logic [47:0] rr, logic [47:0] tr, logic [14:0] h, logic [7:0] c);
		word_out_t o;
		o.sent = s; o.recv = r; o.total = t; o.rxr = rr; o.txr = tr;
		o.hval = h; o.hcnt = c;
		return o;
	endfunction

	row_t dir_tab[$];

	// random sample stream: mostly well-formed, some broken
	task automatic random_phase(int n);
		word_in_t w;
		logic [47:0] spd_t, spd_r, t;
		logic [63:0] rx, tx;
		spd_t = (($urandom % 8) == 0) ? 48'({$urandom, $urandom}) :
			48'(($urandom % 4 + 1)) * GIG;
		spd_r = (($urandom % 8) == 0) ? 48'($urandom % 1000) : spd_t;
		t = 48'({$urandom, $urandom});
		t = t >> ($urandom % 48);
		rx = {$urandom, $urandom} >> ($urandom % 64);
		tx = {$urandom, $urandom} >> ($urandom % 64);
		repeat (n) begin
			w = '0;
			if (($urandom % 8) == 0) begin
				w.kind = KIND_READ;
				w.idx = 7'($urandom);
			end else begin
				w.kind = KIND_SAMPLE;
				t = t + 48'($urandom_range(1, 2000));
				case ($urandom % 16)
					0: t = 48'({$urandom, $urandom});
					1: spd_t = 48'({$urandom, $urandom});
					2: rx = {$urandom, $urandom};
					3: tx = {$urandom, $urandom};
					default: begin
						rx = rx + (64'($urandom) << ($urandom % 33));
						tx = tx + (64'($urandom) << ($urandom % 33));
					end
				endcase
				w.rx = rx; w.tx = tx; w.tx_spd = spd_t; w.rx_spd = spd_r;
				w.now = t; w.up = (($urandom % 20) != 0);
			end
			send_word(w);
		end
	endtask

	initial begin
		word_out_t got;
		mode_q = MODE_TOTAL;
		last_ok = 0; last_up = 0; last_time = 0; last_tx_spd = 0; last_rx_spd = 0;
		last_rx = 0; last_tx = 0; wr_pos = 0; fill = 0;

		// first read sees an empty history
		dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 0), 1,
			res(0, 0, 0, 0, 0, 0, 0)});
		// no previous sample: zeros pushed
		dir_tab.push_back('{mk(KIND_SAMPLE, 0, 0, GIG, GIG, 1000, 1, 0), 1,
			res(0, 0, 0, 0, 0, 0, 1)});
		// 1 s, 62.5 MB each way at 1 Gb/s: 50% each, total 100%
		dir_tab.push_back('{mk(KIND_SAMPLE, 62_500_000, 62_500_000, GIG, GIG, 2000, 1, 0),
			1, res(12800, 12800, 25600, 62_500_000, 62_500_000, 0, 2)});
		// over line rate: clamped
		dir_tab.push_back('{mk(KIND_SAMPLE, 1_000_000_000, 1_000_000_000, GIG, GIG, 3000,
			1, 0), 1, res(25600, 25600, 25600, 937_500_000, 937_500_000, 0, 3)});
		// time stands still
		dir_tab.push_back('{mk(KIND_SAMPLE, 2_000_000_000, 2_000_000_000, GIG, GIG, 3000,
			1, 0), 1, res(0, 0, 0, 0, 0, 0, 4)});
		// counters backward
		dir_tab.push_back('{mk(KIND_SAMPLE, 5, 5, GIG, GIG, 4000, 1, 0), 1,
			res(0, 0, 0, 0, 0, 0, 5)});
		// speed change
		dir_tab.push_back('{mk(KIND_SAMPLE, 10, 10, 2 * GIG, GIG, 5000, 1, 0), 1,
			res(0, 0, 0, 0, 0, 0, 6)});
		// link down now, then down at the previous sample
		dir_tab.push_back('{mk(KIND_SAMPLE, 20, 20, 2 * GIG, GIG, 6000, 0, 0), 1,
			res(0, 0, 0, 0, 0, 0, 7)});
		dir_tab.push_back('{mk(KIND_SAMPLE, 30, 30, 2 * GIG, GIG, 7000, 1, 0), 1,
			res(0, 0, 0, 0, 0, 0, 8)});
		// zero speed on both sides; rates still computed
		dir_tab.push_back('{mk(KIND_SAMPLE, 0, 0, 0, 0, 8000, 1, 0), 0, '0});
		dir_tab.push_back('{mk(KIND_SAMPLE, 64'd1000, 64'd2000, 0, 0, 9000, 1, 0), 0, '0});
		// extremes: full counters, max speed and time
		dir_tab.push_back('{mk(KIND_SAMPLE, '1, '1, MAX48, MAX48, MAX48 - 1, 1, 0), 0, '0});
		dir_tab.push_back('{mk(KIND_SAMPLE, 0, 0, MAX48, MAX48, MAX48, 1, 0), 0, '0});
		dir_tab.push_back('{mk(KIND_SAMPLE, '1, '1, MAX48, MAX48, 48'd1, 1, 0), 0, '0});
		dir_tab.push_back('{mk(KIND_SAMPLE, '1, '1, MAX48, 1, 48'd2, 1, 0), 0, '0});
		dir_tab.push_back('{mk(KIND_SAMPLE, '1, '1, 1, 1, 48'd3, 1, 0), 1,
			res(0, 0, 0, 0, 0, 0, 15)});
		dir_tab.push_back('{mk(KIND_SAMPLE, 64'h8000_0000_0000_0000, 64'h1, 1, 1, 48'd4, 1,
			0), 0, '0});
		// reads: oldest, third oldest, newest, beyond count at the last index
		dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 7'd0), 0, '0});
		dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 7'd2), 0, '0});
		dir_tab.push_back('{mk(KIND_READ, 0, 0, 0, 0, 0, 0, 7'd15), 0, '0});
		dir_tab.push_back('{mk(KIND_READ, '1, '1, MAX48, MAX48, MAX48, 1, 7'd127), 1,
			res(0, 0, 0, 0, 0, 0, 16)});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		foreach (dir_tab[i]) begin
			send_word(dir_tab[i].w);
			if (dir_tab[i].chk) begin
				// hand-typed value replaces the predicted one
				got = expected_q.pop_back();
				if (got != dir_tab[i].r) begin
					$error("table row %0d disagrees with predictor", i);
					err_cnt++;
				end
				expected_q.push_back(dir_tab[i].r);
			end
		end
		drain();
		// read the few entries back in every mode, including the unused code
		for (int m = 0; m < 4; m++) begin
			write_mode(2'(m));
			for (int i = 0; i < 4; i++)
				send_word(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 7'(i)));
			drain();
		end

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			write_mode(2'(ph % 4));
			for (int s = 0; s < 4; s++)
				random_phase(18);
			drain();
		end
		// ring full: sweep every fifth index in each mode
		idle_pct = 19; stall_pct = 19;
		for (int m = 0; m < 3; m++) begin
			write_mode(2'(m));
			for (int i = 0; i < DEPTH; i += 5)
				send_word(mk(KIND_READ, 0, 0, 0, 0, 0, 0, 7'(i)));
			drain();
		end
		stall_pct = 0;
		drain();

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// slowest run: ~1000 words with stalls, far below this
	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
